// ===== hdl/bha_pkg.sv =====
// Shared types, constants and codes of the band height aggregator.
package bha_pkg;

  localparam int BAND_MAX = 64;
  localparam int RAW_BITS = 16;
  localparam int CNT_W    = 7;
  localparam int D_W      = 17;
  localparam int SUM_W    = 23;
  localparam int SQ_W     = 38;
  localparam int VAR_W    = 44;
  localparam int RAD_W    = 76;
  localparam int ROOT_W   = 38;
  localparam int QUO_W    = 38;
  localparam int HGT_W    = 33;

  localparam logic [2:0] MODE_MEAN   = 3'd0;
  localparam logic [2:0] MODE_MIN    = 3'd1;
  localparam logic [2:0] MODE_MAX    = 3'd2;
  localparam logic [2:0] MODE_MEDIAN = 3'd3;
  localparam logic [2:0] MODE_STDDEV = 3'd4;

  localparam logic [1:0] CFG_AGG_MODE     = 2'd0;
  localparam logic [1:0] CFG_ZERO_COUNT   = 2'd1;
  localparam logic [1:0] CFG_HEIGHT_SCALE = 2'd2;

  typedef struct packed {
    logic [15:0] raw_count;
    logic        sample_valid;
    logic        region_ok;
    logic        last_sample;
  } in_data_t;

  typedef struct packed {
    logic signed [HGT_W-1:0] height;
    logic                    height_valid;
    logic [CNT_W-1:0]        valid_count;
  } out_data_t;

  typedef struct packed {
    logic                  ins;
    logic                  shl;
    logic signed [D_W-1:0] d;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_CLOSE,
    S_SHIFT,
    S_MUL,
    S_MULD,
    S_VAR1,
    S_VAR2,
    S_TLO,
    S_THI,
    S_SQGO,
    S_SQW,
    S_DIVW,
    S_EMIT
  } st_t;

endpackage

// ===== hdl/bha_cell.sv =====
// One sorted-chain cell: holds one sample, inserts in order, shifts toward cell zero.
module bha_cell (
  input  logic                           clk,
  input  bha_pkg::cell_ctl_t             ctl,
  input  logic                           occ,
  input  logic signed [bha_pkg::D_W-1:0] prev_val,
  input  logic                           prev_lt,
  input  logic signed [bha_pkg::D_W-1:0] next_val,
  output logic signed [bha_pkg::D_W-1:0] val,
  output logic                           lt
);

  logic signed [bha_pkg::D_W-1:0] val_r;
  logic signed [bha_pkg::D_W-1:0] val_nxt;

  assign lt  = !occ || (ctl.d < val_r);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins && lt) begin
      val_nxt = prev_lt ? prev_val : ctl.d;
    end else if (ctl.shl) begin
      val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== hdl/bha_div.sv =====
// Restoring divider: one quotient bit per cycle.
module bha_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bha_pkg::QUO_W-1:0]  dividend,
  input  logic [bha_pkg::CNT_W-1:0]  divisor,
  output logic [bha_pkg::QUO_W-1:0]  quotient,
  output logic                       done
);

  logic [bha_pkg::QUO_W-1:0] dvd_r;
  logic [bha_pkg::CNT_W-1:0] rem_r;
  logic [bha_pkg::CNT_W-1:0] dsr_r;
  logic [5:0]                cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic [bha_pkg::CNT_W:0]   rem_sh;
  logic                      ge;

  assign rem_sh   = {rem_r, dvd_r[bha_pkg::QUO_W-1]};
  assign ge       = rem_sh >= {1'b0, dsr_r};
  assign quotient = dvd_r;
  assign done     = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == 6'd0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(bha_pkg::QUO_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? bha_pkg::CNT_W'(rem_sh - {1'b0, dsr_r}) : rem_sh[bha_pkg::CNT_W-1:0];
      dvd_r <= {dvd_r[bha_pkg::QUO_W-2:0], ge};
    end
  end

endmodule

// ===== hdl/bha_sqrt.sv =====
// Digit-by-digit integer square root: one root bit per cycle.
module bha_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bha_pkg::RAD_W-1:0]   radicand,
  output logic [bha_pkg::ROOT_W-1:0]  root,
  output logic                        done
);

  logic [bha_pkg::RAD_W-1:0]  rad_r;
  logic [bha_pkg::ROOT_W:0]   rem_r;
  logic [bha_pkg::ROOT_W-1:0] root_r;
  logic [5:0]                 cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [bha_pkg::ROOT_W+2:0] rem_sh;
  logic [bha_pkg::ROOT_W+2:0] trial;
  logic                       ge;

  assign rem_sh = {rem_r, rad_r[bha_pkg::RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = rem_sh >= trial;
  assign root   = root_r;
  assign done   = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == 6'd0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(bha_pkg::ROOT_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[bha_pkg::RAD_W-3:0], 2'b00};
      rem_r  <= ge ? (bha_pkg::ROOT_W+1)'(rem_sh - trial) : rem_sh[bha_pkg::ROOT_W:0];
      root_r <= {root_r[bha_pkg::ROOT_W-2:0], ge};
    end
  end

endmodule

// ===== hdl/band_height_aggregator_unit.sv =====
// Band height aggregator top level: accumulation, sorted sample chain and result sequencer.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | bha_pkg::in_data_t
//   out_    | output    | out_valid/out_stall| bha_pkg::out_data_t
//   cfg_    | input     | cfg_we             | cfg_addr, cfg_wdata
//
// A sample is captured, then inserted into the chain while the sum is updated.
// The last sample adds a closing sequence: a scale multiply for min and max,
// chain shifts by half the count before that multiply for the median, the multiply
// and the divider (one bit per cycle) for the mean, and the square root and
// divider (one bit per cycle each) for the standard deviation.
// Reset (rst_n low, synchronous) clears control state, configuration, accumulators and the output valid flag.
// The result sits in an output register; a stall there holds only the next band's end.
module band_height_aggregator_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bha_pkg::in_data_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bha_pkg::out_data_t  out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [15:0]         cfg_wdata
);

  localparam int N = bha_pkg::BAND_MAX;
  localparam int DW = bha_pkg::D_W;

  bha_pkg::st_t state_r, state_nxt;

  logic [2:0]  mode_r;
  logic [15:0] zero_r;
  logic [15:0] scale_r;

  logic signed [DW-1:0]             d_r;
  logic                             vld_r;
  logic                             last_r;
  logic                             region_r;
  logic [bha_pkg::CNT_W-1:0]        count_r;
  logic signed [bha_pkg::SUM_W-1:0] sum_r;
  logic [bha_pkg::SQ_W-1:0]         sq_r;
  logic signed [DW-1:0]             min_r;
  logic signed [DW-1:0]             max_r;
  logic [31:0]                      sq_prod_r;
  logic                             sq_pend_r;
  logic signed [39:0]               prod_r;
  logic                             neg_r;
  logic [5:0]                       k_r;
  logic [bha_pkg::VAR_W-1:0]        nsq_r;
  logic [bha_pkg::VAR_W-1:0]        s1sq_r;
  logic [31:0]                      scale2_r;
  logic [bha_pkg::VAR_W-1:0]        v_r;
  logic [bha_pkg::RAD_W-1:0]        t_r;
  logic signed [bha_pkg::HGT_W-1:0] res_r;
  logic                             out_valid_r;
  bha_pkg::out_data_t               out_data_r;

  logic                        take;
  logic                        ins_ok;
  logic                        ok;
  logic [2:0]                  eff_mode;
  logic signed [DW-1:0]        d_new;
  logic [DW-1:0]               ad;
  logic signed [bha_pkg::SUM_W-1:0] abs_sum;
  logic signed [39:0]          mul_a;
  logic signed [39:0]          scl_x;
  logic                        emit;
  logic                        div_start;
  logic                        sqrt_start;
  logic [bha_pkg::QUO_W-1:0]   div_dvd;
  logic [bha_pkg::QUO_W-1:0]   div_quot;
  logic                        div_done;
  logic [bha_pkg::ROOT_W-1:0]  sqrt_root;
  logic                        sqrt_done;
  bha_pkg::cell_ctl_t          cell_ctl;

  logic signed [DW-1:0] cval [N];
  logic                 clt  [N];

  assign take     = in_valid && !in_stall;
  assign ins_ok   = vld_r && (count_r != bha_pkg::CNT_W'(N));
  assign ok       = region_r && (count_r != '0);
  assign eff_mode = (mode_r > bha_pkg::MODE_STDDEV) ? bha_pkg::MODE_MEAN : mode_r;
  assign d_new    = $signed({1'b0, in_data.raw_count[bha_pkg::RAW_BITS-1:0]})
                  - $signed({1'b0, zero_r});
  assign ad       = d_r[DW-1] ? DW'(-d_r) : d_r;
  assign abs_sum  = sum_r[bha_pkg::SUM_W-1] ? -sum_r : sum_r;
  assign scl_x    = {24'b0, scale_r};
  assign div_dvd  = (eff_mode == bha_pkg::MODE_STDDEV) ? sqrt_root : prod_r[bha_pkg::QUO_W-1:0];
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    case (eff_mode)
      bha_pkg::MODE_MIN:    mul_a = 40'(min_r);
      bha_pkg::MODE_MAX:    mul_a = 40'(max_r);
      bha_pkg::MODE_MEDIAN: mul_a = 40'(cval[0]);
      default:              mul_a = 40'(abs_sum);
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    in_stall     = 1'b1;
    div_start    = 1'b0;
    sqrt_start   = 1'b0;
    emit         = 1'b0;
    cell_ctl.ins = 1'b0;
    cell_ctl.shl = 1'b0;
    cell_ctl.d   = d_r;
    case (state_r)
      bha_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = bha_pkg::S_ACC;
        end
      end
      bha_pkg::S_ACC: begin
        cell_ctl.ins = ins_ok;
        state_nxt    = last_r ? bha_pkg::S_CLOSE : bha_pkg::S_IDLE;
      end
      bha_pkg::S_CLOSE: begin
        if (!ok) begin
          state_nxt = bha_pkg::S_EMIT;
        end else begin
          case (eff_mode)
            bha_pkg::MODE_MEDIAN: state_nxt = bha_pkg::S_SHIFT;
            bha_pkg::MODE_STDDEV: state_nxt = bha_pkg::S_VAR1;
            default:              state_nxt = bha_pkg::S_MUL;
          endcase
        end
      end
      bha_pkg::S_SHIFT: begin
        if (k_r == '0) begin
          state_nxt = bha_pkg::S_MUL;
        end else begin
          cell_ctl.shl = 1'b1;
        end
      end
      bha_pkg::S_MUL: state_nxt = bha_pkg::S_MULD;
      bha_pkg::S_MULD: begin
        if (eff_mode == bha_pkg::MODE_MEAN) begin
          div_start = 1'b1;
          state_nxt = bha_pkg::S_DIVW;
        end else begin
          state_nxt = bha_pkg::S_EMIT;
        end
      end
      bha_pkg::S_VAR1: state_nxt = bha_pkg::S_VAR2;
      bha_pkg::S_VAR2: state_nxt = bha_pkg::S_TLO;
      bha_pkg::S_TLO:  state_nxt = bha_pkg::S_THI;
      bha_pkg::S_THI:  state_nxt = bha_pkg::S_SQGO;
      bha_pkg::S_SQGO: begin
        sqrt_start = 1'b1;
        state_nxt  = bha_pkg::S_SQW;
      end
      bha_pkg::S_SQW: begin
        if (sqrt_done) begin
          div_start = 1'b1;
          state_nxt = bha_pkg::S_DIVW;
        end
      end
      bha_pkg::S_DIVW: begin
        if (div_done) begin
          state_nxt = bha_pkg::S_EMIT;
        end
      end
      bha_pkg::S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          emit      = 1'b1;
          state_nxt = bha_pkg::S_IDLE;
        end
      end
      default: state_nxt = bha_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bha_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= bha_pkg::MODE_MEAN;
      zero_r  <= '0;
      scale_r <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_addr)
        bha_pkg::CFG_AGG_MODE:     mode_r  <= cfg_wdata[2:0];
        bha_pkg::CFG_ZERO_COUNT:   zero_r  <= cfg_wdata;
        bha_pkg::CFG_HEIGHT_SCALE: scale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      min_r       <= '0;
      max_r       <= '0;
      sq_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sq_pend_r <= (state_r == bha_pkg::S_ACC) && ins_ok;
      if (sq_pend_r) begin
        sq_r <= sq_r + {6'b0, sq_prod_r};
      end
      if (state_r == bha_pkg::S_ACC && ins_ok) begin
        count_r   <= count_r + bha_pkg::CNT_W'(1);
        sum_r     <= sum_r + {{(bha_pkg::SUM_W-DW){d_r[DW-1]}}, d_r};
        if (count_r == '0 || d_r < min_r) begin
          min_r <= d_r;
        end
        if (count_r == '0 || d_r > max_r) begin
          max_r <= d_r;
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
        count_r     <= '0;
        sum_r       <= '0;
        sq_r        <= '0;
        min_r       <= '0;
        max_r       <= '0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      d_r      <= d_new;
      vld_r    <= in_data.sample_valid;
      last_r   <= in_data.last_sample;
      region_r <= in_data.region_ok;
    end
    if (state_r == bha_pkg::S_ACC) begin
      sq_prod_r <= {16'b0, ad[15:0]} * {16'b0, ad[15:0]};
    end
    case (state_r)
      bha_pkg::S_CLOSE: begin
        k_r   <= count_r[6:1];
        neg_r <= sum_r[bha_pkg::SUM_W-1];
        res_r <= '0;
      end
      bha_pkg::S_SHIFT: begin
        if (k_r != '0) begin
          k_r <= k_r - 6'd1;
        end
      end
      bha_pkg::S_MUL: prod_r <= mul_a * scl_x;
      bha_pkg::S_MULD: res_r <= prod_r[bha_pkg::HGT_W-1:0];
      bha_pkg::S_VAR1: begin
        nsq_r    <= {37'b0, count_r} * {6'b0, sq_r};
        s1sq_r   <= {22'b0, abs_sum[21:0]} * {22'b0, abs_sum[21:0]};
        scale2_r <= {16'b0, scale_r} * {16'b0, scale_r};
      end
      bha_pkg::S_VAR2: v_r <= nsq_r - s1sq_r;
      bha_pkg::S_TLO: t_r <= {12'b0, {32'b0, scale2_r} * {32'b0, v_r[31:0]}};
      bha_pkg::S_THI: t_r <= t_r + {({12'b0, scale2_r} * {32'b0, v_r[43:32]}), 32'b0};
      bha_pkg::S_DIVW: begin
        if (div_done) begin
          if (eff_mode == bha_pkg::MODE_MEAN && neg_r) begin
            res_r <= -$signed(div_quot[bha_pkg::HGT_W-1:0]);
          end else begin
            res_r <= div_quot[bha_pkg::HGT_W-1:0];
          end
        end
      end
      default: ;
    endcase
    if (emit) begin
      out_data_r.height       <= res_r;
      out_data_r.height_valid <= ok;
      out_data_r.valid_count  <= count_r;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [DW-1:0] pv;
    logic                 pl;
    logic signed [DW-1:0] nv;
    if (i == 0) begin : g_first
      assign pv = '0;
      assign pl = 1'b0;
    end else begin : g_mid
      assign pv = cval[i-1];
      assign pl = clt[i-1];
    end
    if (i == N - 1) begin : g_last
      assign nv = '0;
    end else begin : g_next
      assign nv = cval[i+1];
    end
    bha_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .occ      (count_r > bha_pkg::CNT_W'(i)),
      .prev_val (pv),
      .prev_lt  (pl),
      .next_val (nv),
      .val      (cval[i]),
      .lt       (clt[i])
    );
  end

  bha_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (count_r),
    .quotient (div_quot),
    .done     (div_done)
  );

  bha_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (t_r),
    .root     (sqrt_root),
    .done     (sqrt_done)
  );

endmodule

// ===== hdl/bha_checker.sv =====
// Port-level checks of the band height aggregator, bound to the top level.
module bha_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input bha_pkg::out_data_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.height_valid |-> out_data.height == '0)
    else $error("invalid result carries nonzero height");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.valid_count <= 7'(bha_pkg::BAND_MAX))
    else $error("valid count beyond band size");

  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken in back-to-back cycles");

endmodule

bind band_height_aggregator_unit bha_checker u_bha_checker (.*);
